// ===== rtl/trle_pkg.sv =====
// Shared types and constants for the tolerance run-length encoder.
package trle_pkg;

	localparam int SAMPLE_W = 8;
	localparam int LEN_W    = 8;
	localparam int QDEPTH   = 4;
	localparam int QAW      = $clog2(QDEPTH);

	// Up to two pairs per sample: one closed or full run, then the flush pair.
	typedef struct packed {
		logic                mid_v;
		logic [LEN_W-1:0]    mid_len;
		logic [SAMPLE_W-1:0] mid_val;
		logic                fl_v;
		logic [LEN_W-1:0]    fl_len;
		logic [SAMPLE_W-1:0] fl_val;
	} trle_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} trle_qstat_t;

endpackage

// ===== rtl/trle_ifs.sv =====
// Valid/ready channel interfaces for samples and emitted runs.
interface trle_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       end_of_channel;

	modport source(output valid, sample, end_of_channel, input ready);
	modport sink(input valid, sample, end_of_channel, output ready);
endinterface

interface trle_run_if;
	logic       valid;
	logic       ready;
	logic [7:0] run_length;
	logic [7:0] run_value;
	logic       closes_channel;
	logic       final_of_item;

	modport source(output valid, run_length, run_value, closes_channel, final_of_item,
		input ready);
	modport sink(input valid, run_length, run_value, closes_channel, final_of_item,
		output ready);
endinterface

// ===== rtl/trle_front.sv =====
// Front end: accepts samples, tracks the open run and classifies each sample.
module trle_front #(
	parameter int MAX_RUN = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	trle_sample_if.sink          samples,
	input  trle_pkg::trle_qstat_t qstat,
	output logic                 push,
	output trle_pkg::trle_entry_t entry
);
	import trle_pkg::*;

	localparam int CW = $clog2(MAX_RUN + 1);

	logic [SAMPLE_W-1:0] tol_q;
	logic [SAMPLE_W-1:0] base_q;
	logic [CW-1:0]       count_q;
	logic                open_q;

	logic [SAMPLE_W-1:0] b_eff;
	logic [CW-1:0]       c_eff;
	logic [SAMPLE_W-1:0] diff;
	logic                close_run;
	logic                full_run;
	logic [SAMPLE_W-1:0] b_new;
	logic [CW-1:0]       c_new;
	logic                accept;

	assign samples.ready = !qstat.full;
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		// A sample that finds no open run starts one as its base.
		b_eff     = open_q ? base_q : samples.sample;
		c_eff     = open_q ? count_q : '0;
		diff      = (samples.sample > b_eff) ? (samples.sample - b_eff)
		                                     : (b_eff - samples.sample);
		close_run = diff > tol_q;
		full_run  = c_eff >= CW'(MAX_RUN);
		b_new     = close_run ? samples.sample : b_eff;
		c_new     = (close_run || full_run) ? CW'(1) : CW'(c_eff + 1'b1);

		entry.mid_v   = close_run || full_run;
		entry.mid_len = LEN_W'(c_eff);
		entry.mid_val = b_eff;
		entry.fl_v    = samples.end_of_channel;
		entry.fl_len  = LEN_W'(c_new);
		entry.fl_val  = b_new;
		push          = accept && (entry.mid_v || entry.fl_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= '0;
			base_q  <= '0;
			count_q <= '0;
			open_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (accept) begin
				base_q  <= b_new;
				count_q <= samples.end_of_channel ? '0 : c_new;
				open_q  <= !samples.end_of_channel;
			end
		end
	end

endmodule

// ===== rtl/trle_queue.sv =====
// Short register queue between the classifying front end and the emitter.
module trle_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  trle_pkg::trle_entry_t entry,
	input  logic                  pop,
	output trle_pkg::trle_entry_t head,
	output trle_pkg::trle_qstat_t qstat
);
	import trle_pkg::*;

	trle_entry_t    mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign qstat.full  = cnt_q == (QAW+1)'(QDEPTH);
	assign qstat.empty = cnt_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/trle_back.sv =====
// Back end: turns each queued entry into one or two run words.
module trle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trle_pkg::trle_entry_t head,
	input  trle_pkg::trle_qstat_t qstat,
	output logic                  pop,
	trle_run_if.source            runs
);
	import trle_pkg::*;

	// Set once the closed-run word of the head entry has gone and its flush word remains.
	logic phase_q;
	logic send_mid;
	logic fire;

	always_comb begin
		send_mid            = head.mid_v && !phase_q;
		runs.valid          = !qstat.empty;
		runs.run_length     = send_mid ? head.mid_len : head.fl_len;
		runs.run_value      = send_mid ? head.mid_val : head.fl_val;
		runs.closes_channel = !send_mid;
		runs.final_of_item  = send_mid ? !head.fl_v : 1'b1;
		fire                = runs.valid && runs.ready;
		pop                 = fire && runs.final_of_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (fire) begin
			phase_q <= !runs.final_of_item;
		end
	end

endmodule

// ===== rtl/tolerance_run_length_encoder.sv =====
// Tolerance run-length encoder top level: front end, queue and run emitter.
// A sample's entry is registered in the queue; its first run word is offered at the head.
// The front end takes one sample per cycle while the queue is not full. The emitter
// sends run words one at a time, so a sample that yields two words holds it for both.
// The four-entry queue absorbs occasional pairs; steady two-word samples fill it.
// Reset clears the tolerance, the open run and the queue.
module tolerance_run_length_encoder #(
	parameter int MAX_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	trle_sample_if.sink samples,
	trle_run_if.source  runs
);
	import trle_pkg::*;

	trle_entry_t entry;
	trle_entry_t head;
	trle_qstat_t qstat;
	logic        push;
	logic        pop;

	trle_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples  (samples),
		.qstat    (qstat),
		.push     (push),
		.entry    (entry)
	);

	trle_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.entry (entry),
		.pop   (pop),
		.head  (head),
		.qstat (qstat)
	);

	trle_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.qstat (qstat),
		.pop   (pop),
		.runs  (runs)
	);

`ifndef SYNTHESIS
	// A word that is not the last of its sample is always followed by the flush word.
	a_flush_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(runs.valid && runs.ready && !runs.final_of_item)
		|=> (runs.valid && runs.closes_channel))
		else $error("flush word missing after a non-final run word");

	// A channel end always leaves at least one word waiting.
	a_eoc_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.end_of_channel) |=> runs.valid)
		else $error("end of channel produced no run word");

	// The flush word is the last word of its sample.
	a_close_final: assert property (@(posedge clk) disable iff (!arst_n)
		(runs.valid && runs.closes_channel) |-> runs.final_of_item)
		else $error("channel-closing word not marked final");

	// The front end never pushes while the queue is full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("queue push while full");
`endif

endmodule
